### src/els_pkg.sv
// Package for the extent list sector translator: constants, payload and control types.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package els_pkg;

    localparam int MAX_EXTENTS   = 16;
    localparam int CHUNK_SECTORS = 12280;
    localparam int MAX_RESULTS   = 22;

    localparam int IDX_W  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SECTORS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_COUNT = CFG_IDX_W'(1);

    localparam logic KIND_LOAD      = 1'b0;
    localparam logic KIND_TRANSLATE = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BEYOND = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  entry_index;
        logic [31:0] entry_first_page;
        logic [31:0] entry_sectors;
        logic [31:0] req_sector;
        logic [15:0] req_count;
    } in_item_t;

    typedef struct packed {
        logic [43:0] chunk_address;
        logic [13:0] chunk_sectors;
        logic [15:0] done_total;
        logic        status;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] first_page;
        logic [31:0] sectors;
    } extent_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        extent_t          data;
    } ram_wr_t;

    typedef struct packed {
        logic [31:0] disk_sectors;
        logic [4:0]  extent_count;
    } cfg_t;

endpackage

`default_nettype wire

### src/els_extent_ram.sv
// Extent table memory: one write port, one read port with registered read data.
// Depends on els_pkg for the entry and write port types.
`default_nettype none

module els_extent_ram
    import els_pkg::*;
(
    input  wire logic             aclk,
    input  wire ram_wr_t          wr,
    input  wire logic [IDX_W-1:0] raddr,
    output extent_t               rdata
);

    extent_t mem [MAX_EXTENTS];
    extent_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/els_cfg_regs.sv
// Configuration register file: disk size and number of extents to walk.
// Depends on els_pkg for register codes and the configuration struct.
`default_nettype none

module els_cfg_regs
    import els_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DISK_SECTORS: cfg_next.disk_sectors = cfg_data[31:0];
                CFG_EXTENT_COUNT: cfg_next.extent_count = cfg_data[4:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/els_walker.sv
// Request sequencer: clips the request, walks the extent table and emits chunks.
// Depends on els_pkg; drives the extent memory's ports and owns the result register.
`default_nettype none

module els_walker
    import els_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire cfg_t      cfg,
    output ram_wr_t        ram_wr,
    output logic [IDX_W-1:0] ram_raddr,
    input  wire extent_t   ram_rdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_EXT   = 5'b00100,
        S_CHUNK = 5'b01000,
        S_FINAL = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [31:0]      start_reg, start_next;
    logic [15:0]      count_reg, count_next;
    logic [15:0]      total_reg, total_next;
    logic [15:0]      emitted_reg, emitted_next;
    logic [31:0]      skip_reg, skip_next;
    logic [31:0]      off_reg, off_next;
    logic [15:0]      left_reg, left_next;
    logic [31:0]      page_reg, page_next;
    logic [CNT_W-1:0] ii_reg, ii_next;
    logic [CNT_W-1:0] walk_reg, walk_next;
    logic [RES_W-1:0] gen_reg, gen_next;
    logic             reject_reg, reject_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [43:0]      pend_addr_reg, pend_addr_next;
    logic [13:0]      pend_secs_reg, pend_secs_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic        out_free;
    logic        accept;
    logic [31:0] remain;
    logic [31:0] ext_left;
    logic [15:0] chunk_n;
    logic [31:0] page_sum;
    logic [43:0] chunk_addr;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign remain     = cfg.disk_sectors - start_reg;
    assign ext_left   = ram_rdata.sectors - skip_reg;
    assign chunk_n    = (32'(left_reg) > CHUNK_SECTORS) ? 16'(CHUNK_SECTORS) : left_reg;
    assign page_sum   = page_reg + {3'b000, off_reg[31:3]};
    assign chunk_addr = {page_sum, off_reg[2:0], 9'd0};

    always_comb begin
        ram_wr.en   = accept && (s_data.kind == KIND_LOAD)
                      && (32'(s_data.entry_index) < MAX_EXTENTS);
        ram_wr.addr = IDX_W'(s_data.entry_index);
        ram_wr.data.first_page = s_data.entry_first_page;
        ram_wr.data.sectors    = s_data.entry_sectors;
    end

    // The read address follows the next extent index so that its entry is ready
    // in the cycle after the index advances.
    assign ram_raddr = ii_next[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        emitted_next    = emitted_reg;
        skip_next       = skip_reg;
        off_next        = off_reg;
        left_next       = left_reg;
        page_next       = page_reg;
        ii_next         = ii_reg;
        walk_next       = walk_reg;
        gen_next        = gen_reg;
        reject_next     = reject_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_secs_next  = pend_secs_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_data.kind == KIND_TRANSLATE)) begin
                    start_next = s_data.req_sector;
                    count_next = s_data.req_count;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                reject_next  = (start_reg >= cfg.disk_sectors);
                count_next   = (32'(count_reg) > remain) ? remain[15:0] : count_reg;
                total_next   = count_next;
                emitted_next = '0;
                skip_next    = start_reg;
                ii_next      = '0;
                gen_next     = '0;
                walk_next    = (32'(cfg.extent_count) > MAX_EXTENTS)
                               ? CNT_W'(MAX_EXTENTS) : CNT_W'(cfg.extent_count);
                state_next   = reject_next ? S_FINAL : S_EXT;
            end
            S_EXT: begin
                if ((ii_reg >= walk_reg) || (count_reg == '0)) begin
                    state_next = S_FINAL;
                end else if (ram_rdata.sectors <= skip_reg) begin
                    skip_next = skip_reg - ram_rdata.sectors;
                    ii_next   = ii_reg + 1'b1;
                end else begin
                    off_next   = skip_reg;
                    left_next  = (ext_left > 32'(count_reg)) ? count_reg : ext_left[15:0];
                    page_next  = ram_rdata.first_page;
                    skip_next  = '0;
                    state_next = S_CHUNK;
                end
            end
            S_CHUNK: begin
                if (32'(gen_reg) >= MAX_RESULTS) begin
                    total_next = emitted_reg;
                    state_next = S_FINAL;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{chunk_address: pend_addr_reg,
                                         chunk_sectors: pend_secs_reg,
                                         done_total: 16'd0,
                                         status: STATUS_OK,
                                         last: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_addr_next  = chunk_addr;
                    pend_secs_next  = chunk_n[13:0];
                    gen_next        = gen_reg + 1'b1;
                    emitted_next    = emitted_reg + chunk_n;
                    left_next       = left_reg - chunk_n;
                    count_next      = count_reg - chunk_n;
                    off_next        = off_reg + 32'(chunk_n);
                    if (left_next == '0) begin
                        ii_next    = ii_reg + 1'b1;
                        state_next = S_EXT;
                    end
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (reject_reg) begin
                        m_data_next = '{chunk_address: 44'd0, chunk_sectors: 14'd0,
                                        done_total: 16'd0, status: STATUS_BEYOND,
                                        last: 1'b1};
                    end else if (pend_valid_reg) begin
                        m_data_next = '{chunk_address: pend_addr_reg,
                                        chunk_sectors: pend_secs_reg,
                                        done_total: total_reg, status: STATUS_OK,
                                        last: 1'b1};
                    end else begin
                        m_data_next = '{chunk_address: 44'd0, chunk_sectors: 14'd0,
                                        done_total: total_reg, status: STATUS_OK,
                                        last: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    reject_next     = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ii_reg         <= '0;
            walk_reg       <= '0;
            gen_reg        <= '0;
            reject_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ii_reg         <= ii_next;
            walk_reg       <= walk_next;
            gen_reg        <= gen_next;
            reject_reg     <= reject_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg     <= start_next;
        count_reg     <= count_next;
        total_reg     <= total_next;
        emitted_reg   <= emitted_next;
        skip_reg      <= skip_next;
        off_reg       <= off_next;
        left_reg      <= left_next;
        page_reg      <= page_next;
        pend_addr_reg <= pend_addr_next;
        pend_secs_reg <= pend_secs_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending chunk left over in idle");

    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(gen_reg) <= MAX_RESULTS)
        else $error("result count beyond limit");

    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr.en |-> (state_reg == S_IDLE))
        else $error("extent table written during a walk");

    a_reject_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == STATUS_BEYOND))
        |-> (m_data_reg.last && (m_data_reg.chunk_sectors == 14'd0)))
        else $error("rejected request result malformed");

    a_final_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FINAL) && out_free) |=> (state_reg == S_IDLE) && m_valid_reg)
        else $error("final result not issued");
`endif

endmodule

`default_nettype wire

### src/extent_list_sector_translator.sv
// Extent list sector translator. A load transaction leaves no result. A translate
// transaction steps through accept, clip, one step per table entry examined, one per
// chunk, one to find the end of the walk or the result limit, and one for the final result;
// output stalls can hold the chunk and final steps, and a rejected request skips the walk.
// Transactions are handled one at a time. Synchronous active-low reset clears the
// configuration and control state; the extent table has no reset value.
`default_nettype none

module extent_list_sector_translator
    import els_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // The configuration registers hold the disk size and the number of extents
    // that a request walks. Writes are always taken; they are expected only
    // while the block is idle.
    cfg_t cfg;

    // The extent table lives in a single synchronous memory. Loads write it from
    // the idle state only and the walk reads it only while busy, so a read and a
    // write of the same entry can never overlap: the sequential handling of
    // transactions acts as the interlock.
    ram_wr_t          ram_wr;
    logic [IDX_W-1:0] ram_raddr;
    extent_t          ram_rdata;

    els_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    els_extent_ram u_ram (
        .aclk  (aclk),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The sequencer clips the request, walks the table and keeps one chunk in
    // hand so that the final chunk can carry the total and the last flag. Its
    // output register lets the next transaction be accepted while the previous
    // result still waits to be taken.
    els_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg       (cfg),
        .ram_wr    (ram_wr),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### test/extent_list_sector_translator_tb.sv
// Self-checking testbench for extent_list_sector_translator: directed and random traffic
// over valid/ready channels, checked against a behavioural predictor of the chunk walk.
// Depends on els_pkg and the block's RTL only.
`timescale 1ns / 1ps

module extent_list_sector_translator_tb
    import els_pkg::*;
();

    // Cycles to let pass once the last expected result has arrived. A load leaves no result,
    // so this lets work that is still in flight, a trailing load for instance, finish.
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 800000;

    // Slot of the directed table that holds the one long extent; every other slot
    // but the first is a single sector long.
    localparam int          LONG_SLOT     = 8;
    localparam logic [31:0] LONG_SECTORS  = 5 * CHUNK_SECTORS + 1;
    localparam logic [31:0] DIRECTED_SPAN = 7 + LONG_SECTORS + 7;

    // A register index that the block does not decode; a write to it changes nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'hFF;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state: the extent table and the two registers as the block should see them.
    logic [31:0] extent_page [MAX_EXTENTS];
    logic [31:0] extent_len  [MAX_EXTENTS];
    logic [31:0] disk_size;
    logic [4:0]  walk_limit;

    out_item_t expected_chunks[$];
    out_item_t oldest_chunk;

    int mismatches     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    extent_list_sector_translator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: a run that stalls or loses results ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[extent_list_sector_translator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Works out the chunks that one translate transaction should produce and queues
    // them. The request is clipped to the disk, extents wholly before the start are
    // skipped, and each extent is cut into pieces of at most CHUNK_SECTORS sectors.
    function automatic void predict_chunks(input logic [31:0] start, input logic [15:0] req);
        logic [31:0] count, total, skip, off, left, n, emitted;
        logic [63:0] addr;
        int          walk, k;
        bit          capped;
        out_item_t   r;
        r = '0;
        if (start >= disk_size) begin
            // A start at or beyond the disk end gives a single rejection.
            r.status = STATUS_BEYOND;
            r.last   = 1'b1;
            expected_chunks.push_back(r);
            return;
        end
        count = 32'(req);
        if (count > disk_size - start)
            count = disk_size - start;
        total   = count;
        walk    = (int'(walk_limit) > MAX_EXTENTS) ? MAX_EXTENTS : int'(walk_limit);
        skip    = start;
        k       = 0;
        emitted = '0;
        capped  = 1'b0;
        for (int i = 0; i < walk && count != 0 && !capped; i++) begin
            if (extent_len[i] <= skip) begin
                skip -= extent_len[i];
            end else begin
                off  = skip;
                left = extent_len[i] - skip;
                if (left > count)
                    left = count;
                while (left != 0 && !capped) begin
                    n = (left > CHUNK_SECTORS) ? 32'(CHUNK_SECTORS) : left;
                    if (k >= MAX_RESULTS) begin
                        capped = 1'b1;
                    end else begin
                        addr = ((64'(extent_page[i]) + 64'(off >> 3)) << 12)
                               + 64'(off[2:0]) * 64'd512;
                        r.chunk_address = addr[43:0];
                        r.chunk_sectors = n[13:0];
                        r.done_total    = '0;
                        r.status        = STATUS_OK;
                        r.last          = 1'b0;
                        expected_chunks.push_back(r);
                        k++;
                        emitted += n;
                        left    -= n;
                        count   -= n;
                        off     += n;
                    end
                end
                skip = '0;
            end
        end
        if (capped)
            total = emitted;
        if (k == 0) begin
            // Nothing to move: an empty chunk that still reports the clipped length.
            r            = '0;
            r.done_total = total[15:0];
            r.last       = 1'b1;
            expected_chunks.push_back(r);
        end else begin
            r            = expected_chunks.pop_back();
            r.done_total = total[15:0];
            r.last       = 1'b1;
            expected_chunks.push_back(r);
        end
    endfunction

    // Sectors covered by the extents that the walk currently looks at.
    function automatic logic [63:0] covered_sectors();
        logic [63:0] span;
        span = '0;
        for (int i = 0; i < MAX_EXTENTS && i < int'(walk_limit); i++)
            span += 64'(extent_len[i]);
        return span;
    endfunction

    // ------------------------------------------------------------------
    // Item builders. Fields that the kind does not use carry random junk so
    // that every bit of the payload toggles.
    // ------------------------------------------------------------------

    function automatic in_item_t load_item(input logic [3:0] slot, input logic [31:0] page,
                                           input logic [31:0] sectors);
        in_item_t item;
        item.kind             = KIND_LOAD;
        item.entry_index      = slot;
        item.entry_first_page = page;
        item.entry_sectors    = sectors;
        item.req_sector       = $urandom();
        item.req_count        = 16'($urandom());
        return item;
    endfunction

    function automatic in_item_t request_item(input logic [31:0] start,
                                              input logic [15:0] count);
        in_item_t item;
        item.kind             = KIND_TRANSLATE;
        item.entry_index      = 4'($urandom_range(15));
        item.entry_first_page = $urandom();
        item.entry_sectors    = $urandom();
        item.req_sector       = start;
        item.req_count        = count;
        return item;
    endfunction

    // Mostly short extents so that walks cross several of them, some that need
    // splitting, the odd empty one and the odd huge one.
    function automatic logic [31:0] random_extent_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return $urandom_range(16, 1);
        if (pick < 70) return $urandom_range(4096, 17);
        if (pick < 90) return $urandom_range(40000, 4097);
        if (pick < 97) return '0;
        return $urandom();
    endfunction

    // Starts mostly land inside the mapped extents; the rest sit near the disk end
    // or anywhere at all.
    function automatic logic [31:0] random_start();
        logic [63:0] span;
        int          pick;
        span = covered_sectors();
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        pick = $urandom_range(99);
        if (pick < 70 && span != 0) return $urandom_range(span[31:0] - 1, 0);
        if (pick < 85) return disk_size - $urandom_range(64, 0);
        return $urandom();
    endfunction

    function automatic logic [15:0] random_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 55) return 16'($urandom_range(512, 1));
        if (pick < 80) return 16'($urandom_range(65535, 513));
        return 16'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers. Inputs change on the falling edge; handshakes are
    // sampled on the rising edge.
    // ------------------------------------------------------------------

    // Offers one transaction, with random idle cycles in front of it, and updates the
    // predictor once the block has taken it.
    task automatic send_item(input in_item_t item);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (item.kind == KIND_LOAD) begin
            extent_page[item.entry_index] = item.entry_first_page;
            extent_len[item.entry_index]  = item.entry_sectors;
        end else begin
            predict_chunks(item.req_sector, item.req_count);
        end
    endtask

    // Only called once the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (index == CFG_DISK_SECTORS)
            disk_size = value;
        else if (index == CFG_EXTENT_COUNT)
            walk_limit = value[4:0];
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Stops offering input, waits for every predicted result, then lets the block
    // finish anything that produces no result (a trailing load, for instance).
    task automatic wait_until_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_chunks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: stalls at random, or holds off entirely while hold_left counts down.
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chunks.size() == 0) begin
                $error("result with no prediction waiting: address 0x%0h, sectors %0d",
                       m_data.chunk_address, m_data.chunk_sectors);
                mismatches++;
            end else begin
                oldest_chunk = expected_chunks.pop_front();
                compare_field("chunk_address", 64'(oldest_chunk.chunk_address),
                              64'(m_data.chunk_address));
                compare_field("chunk_sectors", 64'(oldest_chunk.chunk_sectors),
                              64'(m_data.chunk_sectors));
                compare_field("done_total", 64'(oldest_chunk.done_total),
                              64'(m_data.done_total));
                compare_field("status", 64'(oldest_chunk.status), 64'(m_data.status));
                compare_field("last", 64'(oldest_chunk.last), 64'(m_data.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset the disk size is zero, so every request is turned away
    // without the table being read.
    task automatic test_reset_rejects();
        send_item(request_item(32'h0000_0000, 16'hFFFF));
        send_item(request_item(32'hFFFF_FFFF, 16'h0000));
        wait_until_idle();
    endtask

    // Fills every slot. Slot 0 is empty, the long slot needs six chunks and sits on
    // the top page so that its addresses wrap, and the rest hold one sector each.
    task automatic test_table_load();
        logic [31:0] page;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            case (i % 4)
                0: page = 32'h0000_0000;
                1: page = 32'hFFFF_FFFF;
                2: page = 32'hAAAA_AAAA;
                default: page = 32'h5555_5555;
            endcase
            if (i == LONG_SLOT)
                send_item(load_item(4'(i), 32'hFFFF_FFFF, LONG_SECTORS));
            else if (i == 0)
                send_item(load_item(4'(i), page, 32'd0));
            else
                send_item(load_item(4'(i), page, 32'd1));
        end
        wait_until_idle();
    endtask

    task automatic test_directed_requests();
        write_reg(CFG_DISK_SECTORS, 32'hFFFF_FFFF);
        write_reg(CFG_EXTENT_COUNT, 32'(MAX_EXTENTS));
        // The whole table in twenty chunks; the table ends before the request does.
        send_item(request_item(32'd0, 16'hFFFF));
        send_item(request_item(32'd0, 16'd0));
        // Starts just past the last extent, so nothing is covered.
        send_item(request_item(DIRECTED_SPAN, 16'd10));
        // Lands three sectors into the long extent and crosses a chunk boundary.
        send_item(request_item(32'd10, 16'd20000));
        wait_until_idle();

        // An extent count above the table size is walked as the full table.
        write_reg(CFG_EXTENT_COUNT, 32'd31);
        send_item(request_item(32'd0, 16'hFFFF));
        send_item(request_item(32'hFFFF_FFFE, 16'hFFFF));
        wait_until_idle();

        write_reg(CFG_EXTENT_COUNT, 32'd0);
        send_item(request_item(32'd5, 16'd100));
        wait_until_idle();

        // A small disk: the first request is clipped to one sector, the second starts
        // exactly at the end.
        write_reg(CFG_DISK_SECTORS, 32'd100);
        write_reg(CFG_EXTENT_COUNT, 32'(MAX_EXTENTS));
        send_item(request_item(32'd99, 16'hFFFF));
        send_item(request_item(32'd100, 16'd1));
        wait_until_idle();

        // A write to an undecoded index must leave both registers alone.
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        send_item(request_item(32'd50, 16'd60));
        wait_until_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering, so
    // the block has to fill up and push back on its input.
    task automatic test_receiver_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_DISK_SECTORS, 32'hFFFF_FFFF);
        write_reg(CFG_EXTENT_COUNT, 32'(MAX_EXTENTS));
        @(posedge aclk);
        hold_left = HOLD_OFF_CYCLES;
        repeat (40)
            send_item(request_item(random_start(), 16'($urandom_range(3000, 1))));
        wait_until_idle();
    endtask

    // The sender stops until the block has delivered everything, then carries on.
    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 25;
        repeat (2) begin
            repeat (10)
                send_item(request_item(random_start(), random_count()));
            wait_until_idle();
        end
    endtask

    // Bursts of mostly well-formed requests, each burst under a fresh configuration
    // and with part of the table reloaded; the odd load is mixed in between requests.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int items);
        int          sent;
        int          burst_end;
        int          pick;
        logic [63:0] span;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            wait_until_idle();
            pick = $urandom_range(99);
            if (pick < 60)
                write_reg(CFG_EXTENT_COUNT, 32'(MAX_EXTENTS));
            else if (pick < 80)
                write_reg(CFG_EXTENT_COUNT, $urandom_range(MAX_EXTENTS - 1, 0));
            else
                write_reg(CFG_EXTENT_COUNT, $urandom_range(31, MAX_EXTENTS + 1));
            pick = $urandom_range(99);
            span = covered_sectors();
            if (pick < 40)
                write_reg(CFG_DISK_SECTORS, span > 64'hFFFF_FFFF ?
                          32'hFFFF_FFFF : span[31:0]);
            else if (pick < 55)
                write_reg(CFG_DISK_SECTORS, 32'hFFFF_FFFF);
            else if (pick < 75)
                write_reg(CFG_DISK_SECTORS, $urandom_range(1000, 1));
            else if (pick < 95)
                write_reg(CFG_DISK_SECTORS, $urandom());
            else
                write_reg(CFG_DISK_SECTORS, 32'd0);

            burst_end = sent + $urandom_range(35, 15);
            repeat ($urandom_range(6, 1)) begin
                send_item(load_item(4'($urandom_range(15)), $urandom(),
                                    random_extent_length()));
                sent++;
            end
            while (sent < burst_end && sent < items) begin
                if ($urandom_range(99) < 10)
                    send_item(load_item(4'($urandom_range(15)), $urandom(),
                                        random_extent_length()));
                else
                    send_item(request_item(random_start(), random_count()));
                sent++;
            end
        end
        wait_until_idle();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        disk_size  = '0;
        walk_limit = '0;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            extent_page[i] = '0;
            extent_len[i]  = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_rejects();
        test_table_load();
        test_directed_requests();
        test_receiver_hold_off();
        test_sender_pause();
        test_random_traffic(0, 0, 70);
        test_random_traffic(75, 0, 70);
        test_random_traffic(0, 75, 70);
        test_random_traffic(12, 12, 70);

        if (mismatches == 0 && expected_chunks.size() == 0)
            $display("[extent_list_sector_translator] OK");
        else
            $display("[extent_list_sector_translator] ERROR");
        $finish;
    end

endmodule
